>>> rtl/qeo_pkg.sv
// qeo_pkg: shared types, codes and constants of the encoder odometry block
// no dependencies; every rtl file refers to it by scoped names
package qeo_pkg;

    // number of wheels served by the block (1 to 4, limited by the 2-bit wheel select)
    localparam int WHEELS = 4;
    localparam int WIDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    // field and register widths
    localparam int SEL_W   = 2;
    localparam int CNT_W   = 16;
    localparam int APC_W   = 24;
    localparam int SPC_W   = 32;
    localparam int REV_W   = 4;
    localparam int ALPHA_W = 16;
    localparam int ANGLE_W = 48;
    localparam int SPEED_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_PER_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PER_COUNT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MASK    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA    = 8'd3;

    // default filter weight, 0.8 in Q0.16
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd52429;
    localparam logic [ALPHA_W:0]   ALPHA_ONE   = 17'h10000;

    // item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // tick queue depth
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    // arithmetic widths in the back end
    localparam int CEFF_W = CNT_W + 1;
    localparam int STEP_W = CEFF_W + APC_W + 1;
    localparam int CW_W   = CEFF_W + ALPHA_W + 2;
    localparam int AOLD_W = ALPHA_W + 1 + SPEED_W;
    localparam int RAWW_W = CW_W + SPC_W + 1;
    localparam int ACC_W  = RAWW_W + 1;
    localparam int SHR_W  = ACC_W - 16;

    typedef logic signed [CNT_W-1:0] count_t;
    typedef count_t [WHEELS-1:0] count_vec_t;

    typedef enum logic [1:0] {
        ARM_NONE = 2'd0,
        ARM_UP   = 2'd1,
        ARM_DOWN = 2'd2
    } arm_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_MUL  = 3'd1,
        BK_WIDE = 3'd2,
        BK_SUM  = 3'd3,
        BK_OUT  = 3'd4
    } bk_state_t;

    typedef struct packed {
        logic [APC_W-1:0]   angle_per_count;
        logic [SPC_W-1:0]   speed_per_count;
        logic [REV_W-1:0]   reverse_mask;
        logic [ALPHA_W-1:0] filter_alpha;
    } cfg_t;

    // handshake between the tick queue and its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

>>> rtl/quad_encoder_odometry.sv
// quad_encoder_odometry: top level with configuration registers, front end,
// tick queue and back end; depends on qeo_pkg, qeo_front, qeo_fifo, qeo_back
// Pin samples are taken one per cycle and never stall; their effect is internal.
// A tick is taken when the two-entry tick queue has room; the back end then pops
// it and gives one result per wheel, each held on the output until taken.
// A tick occupies the back end until the result of its last wheel is taken.
// Synchronous active-low reset clears counts, arming, angles, speeds and queue,
// and returns configuration to defaults (filter weight 0.8, the rest zero).
module quad_encoder_odometry (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qeo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qeo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [qeo_pkg::SEL_W-1:0]      s_wheel_sel,
    input  logic                           s_pin_a,
    input  logic                           s_pin_b,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [qeo_pkg::SEL_W-1:0]      m_wheel_out,
    output logic [qeo_pkg::ANGLE_W-1:0]    m_angle,
    output logic [qeo_pkg::SPEED_W-1:0]    m_speed,
    output logic                           m_last
);

    qeo_pkg::cfg_t         cfg_reg, cfg_next;
    qeo_pkg::fifo_status_t fifo_status;
    qeo_pkg::count_vec_t   push_counts;
    qeo_pkg::count_vec_t   pop_counts;
    logic                  push;
    logic                  pop;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                qeo_pkg::CFG_ANGLE_PER_COUNT: begin
                    cfg_next.angle_per_count = cfg_data[qeo_pkg::APC_W-1:0];
                end
                qeo_pkg::CFG_SPEED_PER_COUNT: begin
                    cfg_next.speed_per_count = cfg_data[qeo_pkg::SPC_W-1:0];
                end
                qeo_pkg::CFG_REVERSE_MASK: begin
                    cfg_next.reverse_mask = cfg_data[qeo_pkg::REV_W-1:0];
                end
                qeo_pkg::CFG_FILTER_ALPHA: begin
                    cfg_next.filter_alpha = cfg_data[qeo_pkg::ALPHA_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_per_count <= '0;
            cfg_reg.speed_per_count <= '0;
            cfg_reg.reverse_mask    <= '0;
            cfg_reg.filter_alpha    <= qeo_pkg::ALPHA_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input side: decoders and count snapshots
    qeo_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_wheel_sel (s_wheel_sel),
        .s_pin_a     (s_pin_a),
        .s_pin_b     (s_pin_b),
        .fifo_status (fifo_status),
        .push        (push),
        .push_counts (push_counts)
    );

    // tick queue
    qeo_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_counts),
        .pop       (pop),
        .pop_data  (pop_counts),
        .status    (fifo_status)
    );

    // result side: scaling, angle and speed filter
    qeo_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .fifo_status (fifo_status),
        .pop_counts  (pop_counts),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_wheel_out (m_wheel_out),
        .m_angle     (m_angle),
        .m_speed     (m_speed),
        .m_last      (m_last)
    );

endmodule

>>> rtl/qeo_front.sv
// qeo_front: takes input beats, runs the per-wheel quadrature decoders and
// snapshots the counts into the tick queue; depends on qeo_pkg
module qeo_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic [qeo_pkg::SEL_W-1:0] s_wheel_sel,
    input  logic                      s_pin_a,
    input  logic                      s_pin_b,
    input  qeo_pkg::fifo_status_t     fifo_status,
    output logic                      push,
    output qeo_pkg::count_vec_t       push_counts
);

    qeo_pkg::arm_t   arm_reg  [qeo_pkg::WHEELS];
    qeo_pkg::arm_t   arm_next [qeo_pkg::WHEELS];
    qeo_pkg::count_t cnt_reg  [qeo_pkg::WHEELS];
    qeo_pkg::count_t cnt_next [qeo_pkg::WHEELS];

    logic                       accept;
    logic                       in_range;
    logic [qeo_pkg::WIDX_W-1:0] sel_idx;
    logic                       cnt_zero;

    // samples never wait; a tick waits for room in the queue
    assign s_ready  = (s_func == qeo_pkg::FUNC_SAMPLE) || !fifo_status.full;
    assign accept   = s_valid && s_ready;
    assign in_range = int'(s_wheel_sel) < qeo_pkg::WHEELS;
    assign sel_idx  = qeo_pkg::WIDX_W'(s_wheel_sel);

    // count snapshot carried by a tick
    always_comb begin
        for (int i = 0; i < qeo_pkg::WHEELS; i++) begin
            push_counts[i] = cnt_reg[i];
        end
    end

    // decoder update
    always_comb begin
        push = 1'b0;
        for (int i = 0; i < qeo_pkg::WHEELS; i++) begin
            arm_next[i] = arm_reg[i];
            cnt_next[i] = cnt_reg[i];
        end
        if (accept) begin
            if (s_func == qeo_pkg::FUNC_TICK) begin
                push = 1'b1;
                for (int i = 0; i < qeo_pkg::WHEELS; i++) begin
                    cnt_next[i] = '0;
                end
            end else if (in_range) begin
                if (!s_pin_a) begin
                    // low on A arms the direction from B
                    arm_next[sel_idx] = s_pin_b ? qeo_pkg::ARM_UP : qeo_pkg::ARM_DOWN;
                end else begin
                    // high on A counts once if armed the matching way
                    if (s_pin_b) begin
                        if (arm_reg[sel_idx] == qeo_pkg::ARM_DOWN &&
                            cnt_reg[sel_idx] != {1'b1, {(qeo_pkg::CNT_W-1){1'b0}}}) begin
                            cnt_next[sel_idx] = cnt_reg[sel_idx] - 1'b1;
                        end
                    end else begin
                        if (arm_reg[sel_idx] == qeo_pkg::ARM_UP &&
                            cnt_reg[sel_idx] != {1'b0, {(qeo_pkg::CNT_W-1){1'b1}}}) begin
                            cnt_next[sel_idx] = cnt_reg[sel_idx] + 1'b1;
                        end
                    end
                    arm_next[sel_idx] = qeo_pkg::ARM_NONE;
                end
            end
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < qeo_pkg::WHEELS; i++) begin
                arm_reg[i] <= qeo_pkg::ARM_NONE;
                cnt_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < qeo_pkg::WHEELS; i++) begin
                arm_reg[i] <= arm_next[i];
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // all counts cleared
    always_comb begin
        cnt_zero = 1'b1;
        for (int i = 0; i < qeo_pkg::WHEELS; i++) begin
            if (cnt_reg[i] != '0) begin
                cnt_zero = 1'b0;
            end
        end
    end

    a_tick_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == qeo_pkg::FUNC_TICK) |=> cnt_zero)
        else $error("counts not cleared after tick");

    a_tick_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_status.full)
        else $error("tick pushed into full queue");

endmodule

>>> rtl/qeo_fifo.sv
// qeo_fifo: short queue of count snapshots between the front and back ends
// depends on qeo_pkg for the entry type and depth
module qeo_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  qeo_pkg::count_vec_t   push_data,
    input  logic                  pop,
    output qeo_pkg::count_vec_t   pop_data,
    output qeo_pkg::fifo_status_t status
);

    qeo_pkg::count_vec_t mem_reg [qeo_pkg::FIFO_DEPTH];

    logic [qeo_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [qeo_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [qeo_pkg::FIFO_PTR_W:0]   fill_reg, fill_next;

    assign status.full  = fill_reg == (qeo_pkg::FIFO_PTR_W+1)'(qeo_pkg::FIFO_DEPTH);
    assign status.empty = fill_reg == '0;
    assign pop_data     = mem_reg[rd_ptr_reg];

    // pointer and fill updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == qeo_pkg::FIFO_DEPTH - 1) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == qeo_pkg::FIFO_DEPTH - 1) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/qeo_back.sv
// qeo_back: per-tick sequencer that scales counts, updates angles and runs
// the speed low-pass filter, one wheel at a time; depends on qeo_pkg
module qeo_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  qeo_pkg::cfg_t               cfg,
    input  qeo_pkg::fifo_status_t       fifo_status,
    input  qeo_pkg::count_vec_t         pop_counts,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [qeo_pkg::SEL_W-1:0]   m_wheel_out,
    output logic [qeo_pkg::ANGLE_W-1:0] m_angle,
    output logic [qeo_pkg::SPEED_W-1:0] m_speed,
    output logic                        m_last
);

    qeo_pkg::bk_state_t state_reg, state_next;

    logic [qeo_pkg::WIDX_W-1:0]        idx_reg, idx_next;
    qeo_pkg::count_vec_t               cnt_reg, cnt_next;
    logic signed [qeo_pkg::STEP_W-1:0] step_reg, step_next;
    logic signed [qeo_pkg::CW_W-1:0]   cw_reg, cw_next;
    logic signed [qeo_pkg::AOLD_W-1:0] aold_reg, aold_next;
    logic signed [qeo_pkg::RAWW_W-1:0] raww_reg, raww_next;

    logic [qeo_pkg::ANGLE_W-1:0]        angle_reg  [qeo_pkg::WHEELS];
    logic [qeo_pkg::ANGLE_W-1:0]        angle_next [qeo_pkg::WHEELS];
    logic signed [qeo_pkg::SPEED_W-1:0] speed_reg  [qeo_pkg::WHEELS];
    logic signed [qeo_pkg::SPEED_W-1:0] speed_next [qeo_pkg::WHEELS];

    logic [qeo_pkg::SEL_W-1:0]   wheel_out_reg, wheel_out_next;
    logic [qeo_pkg::ANGLE_W-1:0] angle_out_reg, angle_out_next;
    logic [qeo_pkg::SPEED_W-1:0] speed_out_reg, speed_out_next;
    logic                        last_out_reg, last_out_next;

    logic                              rev;
    logic                              idx_last;
    logic signed [qeo_pkg::CEFF_W-1:0] c_ext;
    logic signed [qeo_pkg::CEFF_W-1:0] c_eff;
    logic signed [qeo_pkg::ACC_W-1:0]  acc;
    logic signed [qeo_pkg::SHR_W-1:0]  shr;
    logic signed [qeo_pkg::SPEED_W-1:0] sat;

    assign m_valid     = state_reg == qeo_pkg::BK_OUT;
    assign m_wheel_out = wheel_out_reg;
    assign m_angle     = angle_out_reg;
    assign m_speed     = speed_out_reg;
    assign m_last      = last_out_reg;
    assign idx_last    = idx_reg == qeo_pkg::WIDX_W'(qeo_pkg::WHEELS - 1);

    // only the first four wheels have a reverse bit
    assign rev   = (int'(idx_reg) < qeo_pkg::REV_W) && cfg.reverse_mask[2'(idx_reg)];
    assign c_ext = qeo_pkg::CEFF_W'(cnt_reg[idx_reg]);
    assign c_eff = rev ? -c_ext : c_ext;

    // rounded filter sum, floor shift and saturation
    assign acc = qeo_pkg::ACC_W'(raww_reg) + qeo_pkg::ACC_W'(aold_reg)
               + qeo_pkg::ACC_W'(32768);
    assign shr = qeo_pkg::SHR_W'(acc >>> 16);
    always_comb begin
        if (shr[qeo_pkg::SHR_W-1:qeo_pkg::SPEED_W-1] == '0 ||
            shr[qeo_pkg::SHR_W-1:qeo_pkg::SPEED_W-1] == '1) begin
            sat = qeo_pkg::SPEED_W'(shr);
        end else if (shr[qeo_pkg::SHR_W-1]) begin
            sat = {1'b1, {(qeo_pkg::SPEED_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(qeo_pkg::SPEED_W-1){1'b1}}};
        end
    end

    // sequencer: next state and datapath
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        cw_next        = cw_reg;
        aold_next      = aold_reg;
        raww_next      = raww_reg;
        wheel_out_next = wheel_out_reg;
        angle_out_next = angle_out_reg;
        speed_out_next = speed_out_reg;
        last_out_next  = last_out_reg;
        pop            = 1'b0;
        for (int i = 0; i < qeo_pkg::WHEELS; i++) begin
            angle_next[i] = angle_reg[i];
            speed_next[i] = speed_reg[i];
        end
        case (state_reg)
            qeo_pkg::BK_IDLE: begin
                if (!fifo_status.empty) begin
                    pop        = 1'b1;
                    cnt_next   = pop_counts;
                    idx_next   = '0;
                    state_next = qeo_pkg::BK_MUL;
                end
            end
            qeo_pkg::BK_MUL: begin
                // angle step, weighted count and decayed old speed
                step_next  = c_eff * $signed({1'b0, cfg.angle_per_count});
                cw_next    = c_eff * $signed({1'b0,
                                 qeo_pkg::ALPHA_ONE - (qeo_pkg::ALPHA_W+1)'(cfg.filter_alpha)});
                aold_next  = $signed({1'b0, cfg.filter_alpha}) * speed_reg[idx_reg];
                state_next = qeo_pkg::BK_WIDE;
            end
            qeo_pkg::BK_WIDE: begin
                // weighted raw speed and wrapping angle
                raww_next           = cw_reg * $signed({1'b0, cfg.speed_per_count});
                angle_next[idx_reg] = angle_reg[idx_reg] + qeo_pkg::ANGLE_W'(step_reg);
                state_next          = qeo_pkg::BK_SUM;
            end
            qeo_pkg::BK_SUM: begin
                speed_next[idx_reg] = sat;
                wheel_out_next      = qeo_pkg::SEL_W'(idx_reg);
                angle_out_next      = angle_reg[idx_reg];
                speed_out_next      = sat;
                last_out_next       = idx_last;
                state_next          = qeo_pkg::BK_OUT;
            end
            qeo_pkg::BK_OUT: begin
                if (m_ready) begin
                    if (idx_last) begin
                        state_next = qeo_pkg::BK_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = qeo_pkg::BK_MUL;
                    end
                end
            end
            default: begin
                state_next = qeo_pkg::BK_IDLE;
            end
        endcase
    end

    // control and wheel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qeo_pkg::BK_IDLE;
            idx_reg   <= '0;
            for (int i = 0; i < qeo_pkg::WHEELS; i++) begin
                angle_reg[i] <= '0;
                speed_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            for (int i = 0; i < qeo_pkg::WHEELS; i++) begin
                angle_reg[i] <= angle_next[i];
                speed_reg[i] <= speed_next[i];
            end
        end
    end

    // datapath and result registers
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        step_reg      <= step_next;
        cw_reg        <= cw_next;
        aold_reg      <= aold_next;
        raww_reg      <= raww_next;
        wheel_out_reg <= wheel_out_next;
        angle_out_reg <= angle_out_next;
        speed_out_reg <= speed_out_next;
        last_out_reg  <= last_out_next;
    end

    a_last_ends_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> state_reg == qeo_pkg::BK_IDLE)
        else $error("sequencer busy after last beat");

    a_mul_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qeo_pkg::BK_MUL) |->
            ($past(state_reg) == qeo_pkg::BK_IDLE || $past(state_reg) == qeo_pkg::BK_OUT))
        else $error("multiply step entered out of order");

    a_last_wheel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> idx_last)
        else $error("last flag on wrong wheel");

endmodule
